/* hw/rtl/gbn_pkg.sv */
// Package for the go-back-n receiver tracker: widths, codes and types.
// No dependencies.
`default_nettype none
package gbn_pkg;
    localparam int unsigned OffsetWidth = 32;
    localparam int unsigned SegWidth    = 16;
    localparam int unsigned WinWidth    = 8;
    localparam int unsigned CntWidth    = 32;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CfgDatWidth = 32;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FEC    = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SEGMENT = 2'd0,
        REG_WINDOW  = 2'd1,
        REG_IMAGE   = 2'd2,
        REG_SPARE   = 2'd3
    } t_reg;

    typedef struct packed {
        logic [1:0]             packet_kind;
        logic [OffsetWidth-1:0] byte_offset;
        logic [SegWidth-1:0]    payload_size;
        logic                   ack_lost;
    } t_in;

    typedef struct packed {
        logic                   ack_valid;
        logic                   ack_is_finish;
        logic [OffsetWidth-1:0] ack_offset;
        logic                   rebuild_valid;
        logic [OffsetWidth-1:0] rebuild_offset;
        logic                   fec_active;
    } t_out;

    typedef struct packed {
        logic [CfgIdxWidth-1:0] index;
        logic [CfgDatWidth-1:0] data;
    } t_cfg;

    typedef struct packed {
        logic                   start;
        logic [OffsetWidth-1:0] dividend;
        logic [SegWidth-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [OffsetWidth-1:0] quotient;
        logic [SegWidth-1:0]    remainder;
    } t_div_rsp;
endpackage
`default_nettype wire

/* hw/rtl/gbn_if.sv */
// Valid/ready channel interfaces for items and configuration writes.
// Depends on gbn_pkg.
`default_nettype none
interface gbn_in_if;
    logic        valid;
    logic        ready;
    gbn_pkg::t_in payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface gbn_out_if;
    logic         valid;
    logic         ready;
    gbn_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface gbn_cfg_if;
    logic         valid;
    logic         ready;
    gbn_pkg::t_cfg payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hw/rtl/gbn_div.sv */
// Restoring divider, one quotient bit per cycle, 32 by 16 bits.
// Depends on gbn_pkg.
`default_nettype none
module gbn_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gbn_pkg::t_div_req i_req,
    output gbn_pkg::t_div_rsp      o_rsp
);
    localparam int unsigned W = gbn_pkg::OffsetWidth;
    localparam int unsigned D = gbn_pkg::SegWidth;
    localparam int unsigned CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W-1:0]  r_q, n_q;
    logic [D:0]    r_rem, n_rem;
    logic [D-1:0]  r_dvs, n_dvs;
    logic [D:0]    w_trial;
    logic [D:0]    w_diff;

    always_comb begin
        w_trial = {r_rem[D-1:0], r_q[W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_q    = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[D]) begin
                n_rem = w_diff;
                n_q   = {r_q[W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem[D-1:0];
endmodule
`default_nettype wire

/* hw/rtl/gbn_fec_receiver_tracker.sv */
// Go-back-n receiver tracker with XOR FEC window, top level.
// A data packet that returns to FEC mode needs a second division; FEC,
// finish and unknown kinds, like other data packets, need only one.
// A new item is taken only when idle, after the result is accepted, so a
// result stall holds the flow; the serial divider (one bit a cycle) sets the rate.
// Synchronous active-low reset clears all tracking state, FEC mode on.
// Depends on gbn_pkg, gbn_if and gbn_div.
`default_nettype none
module gbn_fec_receiver_tracker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gbn_in_if.sink     i_in,
    gbn_out_if.source  o_out,
    gbn_cfg_if.sink    i_cfg
);
    localparam int unsigned W = gbn_pkg::OffsetWidth;
    localparam int unsigned S = gbn_pkg::SegWidth;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV1 = 5'b00010,
        ST_DIV2 = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [S-1:0] r_seg;
    logic [gbn_pkg::WinWidth-1:0] r_win;
    logic [W-1:0] r_img;
    logic [W-1:0] r_exp, r_ws, r_lack, r_ldat;
    logic [gbn_pkg::CntWidth-1:0] r_cnt;
    logic r_fec;
    gbn_pkg::t_in  r_item;
    gbn_pkg::t_out r_res;
    logic r_div_go;
    logic [W-1:0] r_dvd;

    gbn_pkg::t_div_req w_req;
    gbn_pkg::t_div_rsp w_rsp;
    logic [S-1:0] w_dvs;

    assign w_dvs = (r_seg == '0) ? S'(1) : r_seg;
    assign w_req.start    = r_div_go;
    assign w_req.dividend = r_dvd;
    assign w_req.divisor  = w_dvs;

    gbn_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign i_in.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready  = (r_state == ST_IDLE);
    assign o_out.valid  = (r_state == ST_OUT);
    assign o_out.payload = r_res;

    // step evaluation after first division
    logic [W-1:0] e_exp, e_ws, e_lack, e_ldat, e_aoff, e_rboff, e_sum, e_seqsz;
    logic [gbn_pkg::CntWidth-1:0] e_cnt;
    logic e_fec, e_ack, e_fin, e_rb, e_need2, tg;
    logic [W-1:0] num;
    logic [W:0] tgt_n;
    logic [W+1:0] cnt_x, tgt_x;
    logic [S+gbn_pkg::WinWidth-1:0] e_adv;

    always_comb begin
        num = w_rsp.quotient;
        e_exp = r_exp; e_ws = r_ws; e_lack = r_lack; e_ldat = r_ldat;
        e_cnt = r_cnt; e_fec = r_fec;
        e_ack = 1'b0; e_fin = 1'b0; e_rb = 1'b0; e_aoff = '0; e_rboff = '0;
        e_need2 = 1'b0; tg = 1'b0;
        e_adv = (S+gbn_pkg::WinWidth)'(r_win) * (S+gbn_pkg::WinWidth)'(r_seg);
        e_sum = r_exp + W'(r_item.payload_size);
        e_seqsz = r_item.byte_offset + W'(r_item.payload_size);
        tgt_n = {1'b0, num} + ((w_rsp.remainder != '0) ? (W+1)'(1) : '0);
        tgt_x = {1'b0, tgt_n} - (W+2)'(1);
        cnt_x = (W+2)'(r_cnt);
        unique case (gbn_pkg::t_kind'(r_item.packet_kind))
            gbn_pkg::KIND_DATA: begin
                if (num >= W'(r_win) && e_fec) begin
                    if (e_cnt == gbn_pkg::CntWidth'(r_win)) begin
                        e_cnt = '0;
                        e_ws = e_ws + W'(e_adv);
                    end else begin
                        e_fec = 1'b0; e_cnt = '0; e_ws = r_lack;
                    end
                end
                if (r_item.byte_offset == r_exp) begin
                    e_exp = e_sum; e_aoff = e_sum; e_ack = 1'b1;
                    if (e_fec) e_cnt = e_cnt + gbn_pkg::CntWidth'(1);
                    else begin
                        e_fec = 1'b1; e_need2 = 1'b1;
                    end
                end else if (r_item.byte_offset < r_exp) begin
                    e_aoff = r_exp; e_ack = 1'b1;
                end else if (e_fec) begin
                    tg = r_item.byte_offset <= r_ldat;
                    if (!tg) begin
                        e_cnt = e_cnt + gbn_pkg::CntWidth'(1);
                        tg = (e_cnt < num) && (e_seqsz == r_img);
                    end
                    if (tg) begin
                        e_fec = 1'b0; e_ws = r_lack; e_cnt = '0;
                    end
                end
                e_ldat = r_item.byte_offset;
            end
            gbn_pkg::KIND_FEC: begin
                if (e_fec) begin
                    if (num > W'(r_win) || $signed(cnt_x) < $signed(tgt_x)) begin
                        e_fec = 1'b0; e_ws = r_lack;
                    end else if (cnt_x == tgt_x) begin
                        e_rb = 1'b1; e_rboff = r_exp; e_aoff = r_item.byte_offset;
                        e_ack = 1'b1; e_exp = r_item.byte_offset;
                        e_ws = r_item.byte_offset;
                    end else e_ws = r_item.byte_offset;
                    e_cnt = '0;
                end
            end
            gbn_pkg::KIND_FINISH: begin
                e_ack = 1'b1; e_fin = 1'b1;
            end
            default: ;
        endcase
        if (e_ack && r_item.ack_lost) begin
            e_ack = 1'b0; e_fin = 1'b0; e_aoff = '0;
        end else if (e_ack && !e_fin) e_lack = e_aoff;
        if (!e_ack) e_aoff = '0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_WAIT;
            ST_WAIT: n_state = ST_DIV1;
            ST_DIV1: if (w_rsp.done) n_state = e_need2 ? ST_DIV2 : ST_OUT;
            ST_DIV2: if (w_rsp.done) n_state = ST_OUT;
            ST_OUT:  if (o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
            r_state <= ST_IDLE;
            r_seg <= S'(1); r_win <= gbn_pkg::WinWidth'(1); r_img <= '0;
            r_exp <= '0; r_ws <= '0; r_lack <= '0; r_ldat <= '0;
            r_cnt <= '0; r_fec <= 1'b1;
        end else begin
            r_state <= n_state;
            r_div_go <= (r_state == ST_WAIT)
                || (r_state == ST_DIV1 && w_rsp.done && e_need2);
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (gbn_pkg::t_reg'(i_cfg.payload.index))
                    gbn_pkg::REG_SEGMENT: r_seg <= i_cfg.payload.data[S-1:0];
                    gbn_pkg::REG_WINDOW:
                        r_win <= i_cfg.payload.data[gbn_pkg::WinWidth-1:0];
                    gbn_pkg::REG_IMAGE: r_img <= i_cfg.payload.data[W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_DIV1 && w_rsp.done) begin
                r_exp <= e_exp; r_ws <= e_ws; r_lack <= e_lack; r_ldat <= e_ldat;
                r_cnt <= e_cnt; r_fec <= e_fec;
            end
            if (r_state == ST_DIV2 && w_rsp.done) r_cnt <= w_rsp.quotient;
        end
        if (r_state == ST_IDLE && i_in.valid) r_item <= i_in.payload;
        if (r_state == ST_WAIT) r_dvd <= r_item.byte_offset - r_ws;
        if (r_state == ST_DIV1 && w_rsp.done) begin
            r_dvd <= e_exp - e_ws;
            r_res.ack_valid <= e_ack;
            r_res.ack_is_finish <= e_fin;
            r_res.ack_offset <= e_aoff;
            r_res.rebuild_valid <= e_rb;
            r_res.rebuild_offset <= e_rboff;
            r_res.fec_active <= e_fec;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(o_out.payload))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_in.ready)
        else $error("input ready while busy");
    a_fin_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.ack_is_finish |-> o_out.payload.ack_valid
            && o_out.payload.ack_offset == '0)
        else $error("finish ack malformed");
endmodule
`default_nettype wire
